// File: hw/rtl/lpcd_pkg.sv
// Package for the page cache directory: sizes, field widths, codes,
// state machine encoding and the result record.
// Used by lru_page_cache_directory and its testbench; depends on nothing.
package lpcd_pkg;

	// Built geometry of the directory.
	localparam int SLOTS      = 64;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int PAGE_BYTES = 4096;
	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int KEY_BITS   = 64;

	// Fixed widths of the stream and register fields.
	localparam int KEY_FIELD_W = 64;
	localparam int OFF_FIELD_W = 12;
	localparam int ADDR_W      = 18;
	localparam int LIMIT_W     = 7;
	localparam int SLOT_FIELD_W = 6;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 96;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	// Reset value of the page limit register.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOTS);

	// Request kinds carried on tuser.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Register word index (paddr bit 2 selects the word).
	localparam logic REG_PAGE_LIMIT = 1'b0;

	// Request sequencer.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// One result beat, laid out so that hit sits in bit 0 of tdata.
	typedef struct packed {
		logic [OUT_DATA_W-KEY_FIELD_W-ADDR_W-SLOT_FIELD_W-4-1:0] pad;
		logic [KEY_FIELD_W-1:0]  evicted_key;
		logic                    evicted;
		logic                    fetch_needed;
		logic [ADDR_W-1:0]       cache_address;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    slot_valid;
		logic                    hit;
	} res_t;

endpackage

// File: hw/rtl/lpcd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the slot key and slot age stores; depends on nothing.
module lpcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/lru_page_cache_directory.sv
// Top level of the fully associative LRU page cache directory.
// Depends on lpcd_pkg and lpcd_ram (slot key store and slot age store).
//
// One request is handled at a time. With N slots in use, one pass of N
// reads through the key and age memories finds the hit slot and the oldest
// slot, then a read-modify-write pass over the age memory renumbers the
// recency ranks. A write miss skips the second pass. The memories have one
// read and one write port each, which sets one slot per cycle in both passes.
// A new request is taken while the previous result still waits on the
// output register. Entries at or above the fill count never reach a result,
// so the memories need no clearing pass after reset.
module lru_page_cache_directory (
	input  logic clk,
	input  logic arst_n,

	// Request stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata: page_key[63:0], byte_offset[75:64], zero fill.
	input  logic [lpcd_pkg::IN_DATA_W-1:0] s_tdata,
	// tuser: cmd.
	input  logic                           s_tuser,

	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: hit[0], slot_valid[1], slot[7:2], cache_address[25:8],
	// fetch_needed[26], evicted[27], evicted_key[91:28], zero fill.
	output logic [lpcd_pkg::OUT_DATA_W-1:0] m_tdata,

	// Register port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpcd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpcd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lpcd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int SW = lpcd_pkg::SLOT_W;
	localparam int CW = lpcd_pkg::CNT_W;
	localparam int KW = lpcd_pkg::KEY_BITS;
	localparam int OW = lpcd_pkg::OFF_W;

	lpcd_pkg::state_t state_q, state_d;

	logic [lpcd_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0]                lim_eff;
	logic [CW-1:0]                used_q;

	// Request being worked on.
	logic          cmd_q;
	logic [KW-1:0] key_q;
	logic [OW-1:0] off_q;

	// Scan counter and the read in flight.
	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [SW-1:0] pend_idx_s1;

	// Search results.
	logic          found_q;
	logic [SW-1:0] hit_slot_q;
	logic [SW-1:0] hit_age_q;
	logic [SW-1:0] old_slot_q;
	logic [KW-1:0] old_key_q;

	// Recency update parameters.
	logic [SW-1:0] sel_slot_q;
	logic [CW-1:0] old_age_q;
	logic [CW-1:0] span_q;

	lpcd_pkg::res_t res_d;
	lpcd_pkg::res_t res_q;
	lpcd_pkg::res_t out_q;
	logic           m_tvalid_q;

	// Memory ports.
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic [KW-1:0] key_rdata;
	logic [SW-1:0] age_rdata;
	logic          key_we;
	logic [SW-1:0] key_waddr;
	logic          age_we;
	logic [SW-1:0] age_wdata;
	logic          alloc;
	logic          rd_miss;
	logic          s_accept;
	logic          out_free;
	logic          cfg_write;

	lpcd_ram #(
		.WIDTH(KW),
		.DEPTH(lpcd_pkg::SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_q),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(key_rdata)
	);

	lpcd_ram #(
		.WIDTH(SW),
		.DEPTH(lpcd_pkg::SLOTS)
	) u_age_ram (
		.clk  (clk),
		.we   (age_we),
		.waddr(pend_idx_s1),
		.wdata(age_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(age_rdata)
	);

	// Register port: always ready, one register at word zero.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == lpcd_pkg::REG_PAGE_LIMIT) ?
		lpcd_pkg::APB_DATA_W'(limit_q) : '0;

	// Effective limit: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = CW'(1);
		end else if (CW'(limit_q) > CW'(lpcd_pkg::SLOTS)) begin
			lim_eff = CW'(lpcd_pkg::SLOTS);
		end else begin
			lim_eff = CW'(limit_q);
		end
	end

	assign s_tready = (state_q == lpcd_pkg::ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_miss  = !found_q && (cmd_q == lpcd_pkg::CMD_READ);
	assign alloc    = used_q < lim_eff;
	assign rd_addr  = idx_q[SW-1:0];
	assign key_waddr = alloc ? used_q[SW-1:0] : old_slot_q;

	// New rank: the touched slot becomes zero, younger slots age by one.
	always_comb begin
		if (pend_idx_s1 == sel_slot_q) begin
			age_wdata = '0;
		end else if (CW'(age_rdata) < old_age_q) begin
			age_wdata = age_rdata + SW'(1);
		end else begin
			age_wdata = age_rdata;
		end
	end

	// Result of the request once the search is over.
	always_comb begin
		res_d = '0;
		if (found_q) begin
			res_d.hit           = 1'b1;
			res_d.slot_valid    = 1'b1;
			res_d.slot          = lpcd_pkg::SLOT_FIELD_W'(hit_slot_q);
			res_d.cache_address = lpcd_pkg::ADDR_W'({hit_slot_q, off_q});
		end else if (rd_miss && alloc) begin
			res_d.slot_valid    = 1'b1;
			res_d.fetch_needed  = 1'b1;
			res_d.slot          = lpcd_pkg::SLOT_FIELD_W'(used_q[SW-1:0]);
			res_d.cache_address = lpcd_pkg::ADDR_W'({used_q[SW-1:0], off_q});
		end else if (rd_miss) begin
			res_d.slot_valid    = 1'b1;
			res_d.fetch_needed  = 1'b1;
			res_d.evicted       = 1'b1;
			res_d.evicted_key   = lpcd_pkg::KEY_FIELD_W'(old_key_q);
			res_d.slot          = lpcd_pkg::SLOT_FIELD_W'(old_slot_q);
			res_d.cache_address = lpcd_pkg::ADDR_W'({old_slot_q, off_q});
		end
	end

	// Sequencer next state and memory strobes.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		key_we  = 1'b0;
		age_we  = 1'b0;
		case (state_q)
			lpcd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = lpcd_pkg::ST_SEARCH;
				end
			end
			lpcd_pkg::ST_SEARCH: begin
				if (idx_q < used_q) begin
					rd_en = 1'b1;
				end else if (!pend_s1) begin
					state_d = lpcd_pkg::ST_DECIDE;
				end
			end
			lpcd_pkg::ST_DECIDE: begin
				key_we  = rd_miss;
				state_d = (found_q || rd_miss) ? lpcd_pkg::ST_UPDATE : lpcd_pkg::ST_DONE;
			end
			lpcd_pkg::ST_UPDATE: begin
				age_we = pend_s1;
				if (idx_q < span_q) begin
					rd_en = 1'b1;
				end else if (!pend_s1) begin
					state_d = lpcd_pkg::ST_DONE;
				end
			end
			lpcd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lpcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpcd_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: limit, fill count, scan counter, read pending, found flag, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= lpcd_pkg::LIMIT_RESET;
			used_q     <= '0;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == lpcd_pkg::REG_PAGE_LIMIT) begin
				limit_q <= pwdata[lpcd_pkg::LIMIT_W-1:0];
			end
			pend_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (s_accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (pend_s1 && state_q == lpcd_pkg::ST_SEARCH && !found_q &&
				key_rdata == key_q) begin
				found_q <= 1'b1;
			end
			if (state_q == lpcd_pkg::ST_DECIDE) begin
				idx_q <= '0;
				if (rd_miss && alloc) begin
					used_q <= used_q + CW'(1);
				end
			end
			if (state_q == lpcd_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, search captures, recency update parameters, result.
	always_ff @(posedge clk) begin
		pend_idx_s1 <= rd_addr;
		if (s_accept) begin
			cmd_q <= s_tuser;
			key_q <= s_tdata[KW-1:0];
			off_q <= s_tdata[lpcd_pkg::KEY_FIELD_W +: OW];
		end
		if (pend_s1 && state_q == lpcd_pkg::ST_SEARCH) begin
			if (!found_q && key_rdata == key_q) begin
				hit_slot_q <= pend_idx_s1;
				hit_age_q  <= age_rdata;
			end
			if (age_rdata == SW'(used_q - CW'(1))) begin
				old_slot_q <= pend_idx_s1;
				old_key_q  <= key_rdata;
			end
		end
		if (state_q == lpcd_pkg::ST_DECIDE) begin
			res_q <= res_d;
			if (found_q) begin
				sel_slot_q <= hit_slot_q;
				old_age_q  <= CW'(hit_age_q);
				span_q     <= used_q;
			end else if (rd_miss && alloc) begin
				sel_slot_q <= used_q[SW-1:0];
				old_age_q  <= used_q;
				span_q     <= used_q + CW'(1);
			end else if (rd_miss) begin
				sel_slot_q <= old_slot_q;
				old_age_q  <= used_q - CW'(1);
				span_q     <= used_q;
			end
		end
		if (state_q == lpcd_pkg::ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// The fill count never passes the built depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(lpcd_pkg::SLOTS))
		else $error("fill count above depth");

	// The fill count only ever grows by one slot at a time.
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + CW'(1)))
		else $error("fill count jumped");

	// Every rank written back stays inside the set of used slots.
	a_age_range: assert property (@(posedge clk) disable iff (!arst_n)
		age_we |-> (CW'(age_wdata) < span_q))
		else $error("recency rank out of range");

	// A fetch goes with a valid slot and never with a hit.
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.fetch_needed) |-> (out_q.slot_valid && !out_q.hit))
		else $error("fetch without a slot or on a hit");

	// An eviction only happens on a read miss that fetches.
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q.evicted) |-> out_q.fetch_needed)
		else $error("eviction without fetch");

endmodule

// File: dv/lru_page_cache_directory_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU page cache directory: a table of directed
// requests, then random phases under several page limits, checked beat by beat.
// Depends on lpcd_pkg and the lru_page_cache_directory RTL.
module lru_page_cache_directory_tb;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 150;
	localparam logic [lpcd_pkg::APB_ADDR_W-1:0] LIMIT_ADDR =
		{lpcd_pkg::REG_PAGE_LIMIT, 2'b00};

	localparam logic [63:0] KEY_ZERO = 64'h0;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_A    = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] KEY_B    = 64'hFEDC_BA98_7654_3210;
	localparam logic [63:0] KEY_C    = 64'h8000_0000_0000_0001;
	localparam logic [63:0] KEY_D    = 64'h5A5A_A5A5_5A5A_A5A5;
	localparam logic [63:0] KEY_E    = 64'h0F0F_0F0F_0F0F_0F0F;

	// One row of the directed table: either a page limit write or a request.
	typedef struct {
		bit             is_cfg;
		logic [31:0]    word;
		logic           cmd;
		logic [63:0]    key;
		logic [11:0]    off;
		bit             typed;
		lpcd_pkg::res_t want;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// tdata: page_key[63:0], byte_offset[75:64], zero fill.
	logic [lpcd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	// tuser: cmd.
	logic                            s_tuser = lpcd_pkg::CMD_READ;

	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// tdata: hit, slot_valid, slot, cache_address, fetch_needed, evicted,
	// evicted_key, zero fill.
	logic [lpcd_pkg::OUT_DATA_W-1:0] m_tdata;

	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [lpcd_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [lpcd_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [lpcd_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	// Shadow directory that predicts every result beat.
	logic [63:0] dir_keys [lpcd_pkg::SLOTS];
	int          dir_ranks [lpcd_pkg::SLOTS];
	int          dir_fill = 0;
	logic [lpcd_pkg::LIMIT_W-1:0] limit_reg = lpcd_pkg::LIMIT_RESET;

	lpcd_pkg::res_t expected_results [$];
	logic [63:0] page_pool [$];
	int          errors = 0;
	int unsigned cycles = 0;
	bit          no_idle = 1'b0;
	int          hold_requests = 0;

	lru_page_cache_directory uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Effective number of slots: zero acts as one, anything above the depth as the depth.
	function automatic int usable_slots();
		if (limit_reg == 0)
			return 1;
		if (limit_reg > lpcd_pkg::SLOTS)
			return lpcd_pkg::SLOTS;
		return int'(limit_reg);
	endfunction

	// Make slot s most recent; every slot more recent than its old rank ages by one.
	function automatic void promote(int s, int old_rank);
		for (int i = 0; i < dir_fill; i++)
			if (dir_ranks[i] < old_rank)
				dir_ranks[i]++;
		dir_ranks[s] = 0;
	endfunction

	// Look up one request in the shadow directory, update it and return the result.
	function automatic lpcd_pkg::res_t serve_request(logic cmd, logic [63:0] key,
			logic [11:0] off);
		lpcd_pkg::res_t r;
		int   s;
		bit   found;
		bit   picked;
		r = '0;
		s = 0;
		found = 1'b0;
		picked = 1'b0;
		for (int i = 0; i < dir_fill; i++)
			if (!found && dir_keys[i] == key) begin
				found = 1'b1;
				s = i;
			end
		if (found) begin
			promote(s, dir_ranks[s]);
			r.hit = 1'b1;
			r.slot_valid = 1'b1;
		end else if (cmd == lpcd_pkg::CMD_READ) begin
			if (dir_fill < usable_slots()) begin
				s = dir_fill;
				dir_fill++;
				dir_keys[s] = key;
				promote(s, dir_fill - 1);
			end else begin
				// Full, or the limit was lowered below use: displace the least recent slot.
				for (int i = 0; i < dir_fill; i++)
					if (!picked && dir_ranks[i] == dir_fill - 1) begin
						picked = 1'b1;
						s = i;
					end
				r.evicted = 1'b1;
				r.evicted_key = dir_keys[s];
				dir_keys[s] = key;
				promote(s, dir_ranks[s]);
			end
			r.slot_valid = 1'b1;
			r.fetch_needed = 1'b1;
		end
		if (r.slot_valid) begin
			r.slot = lpcd_pkg::SLOT_FIELD_W'(s);
			r.cache_address = lpcd_pkg::ADDR_W'(s * lpcd_pkg::PAGE_BYTES + int'(off));
		end
		return r;
	endfunction

	function automatic lpcd_pkg::res_t outcome(bit hit, bit valid, int slot, int addr,
			bit fetch, bit ev, logic [63:0] ev_key);
		lpcd_pkg::res_t r;
		r = '0;
		r.hit = hit;
		r.slot_valid = valid;
		r.slot = lpcd_pkg::SLOT_FIELD_W'(slot);
		r.cache_address = lpcd_pkg::ADDR_W'(addr);
		r.fetch_needed = fetch;
		r.evicted = ev;
		r.evicted_key = ev_key;
		return r;
	endfunction

	function automatic probe_t ask(logic cmd, logic [63:0] key, int off, bit typed,
			lpcd_pkg::res_t want);
		probe_t p;
		p.is_cfg = 1'b0;
		p.word = '0;
		p.cmd = cmd;
		p.key = key;
		p.off = lpcd_pkg::OFF_FIELD_W'(off);
		p.typed = typed;
		p.want = want;
		return p;
	endfunction

	function automatic probe_t set_limit(logic [31:0] word);
		probe_t p;
		p = ask(lpcd_pkg::CMD_READ, KEY_ZERO, 0, 1'b0, '0);
		p.is_cfg = 1'b1;
		p.word = word;
		return p;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Register read: setup phase, then access phase; the bus goes idle after it.
	task automatic read_page_limit(output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register write followed by a read back of the stored value.
	task automatic write_page_limit(input logic [31:0] word);
		logic [31:0] seen;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		limit_reg = word[lpcd_pkg::LIMIT_W-1:0];
		@(posedge clk);
		read_page_limit(seen);
		check_field("page_limit", 64'(word[lpcd_pkg::LIMIT_W-1:0]), 64'(seen));
	endtask

	// Offer one request beat, maybe after a random gap, and record its expected result.
	task automatic offer_request(input logic cmd, input logic [63:0] key,
			input logic [11:0] off, input bit typed, input lpcd_pkg::res_t want);
		lpcd_pkg::res_t predicted;
		if (!no_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 150)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(lpcd_pkg::IN_DATA_W - lpcd_pkg::KEY_FIELD_W -
			lpcd_pkg::OFF_FIELD_W){1'b0}}, off, key};
		do @(posedge clk); while (!s_tready);
		predicted = serve_request(cmd, key, off);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Stop sending and wait until every outstanding result beat has arrived.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Result sink: random back-pressure, long hold-offs on request, steady stretches.
	initial begin : result_sink
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (no_idle)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 34);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		lpcd_pkg::res_t got;
		lpcd_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = lpcd_pkg::res_t'(m_tdata);
			if (expected_results.size() == 0) begin
				$error("result beat with no request outstanding: %0h", m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 64'(want.hit), 64'(got.hit));
				check_field("slot_valid", 64'(want.slot_valid), 64'(got.slot_valid));
				check_field("slot", 64'(want.slot), 64'(got.slot));
				check_field("cache_address", 64'(want.cache_address), 64'(got.cache_address));
				check_field("fetch_needed", 64'(want.fetch_needed), 64'(got.fetch_needed));
				check_field("evicted", 64'(want.evicted), 64'(got.evicted));
				check_field("evicted_key", want.evicted_key, got.evicted_key);
				check_field("pad", 64'(want.pad), 64'(got.pad));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lru_page_cache_directory_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		probe_t      probes [$];
		logic [31:0] word;
		logic [31:0] seen;
		int          phase_limit [10];
		int          phase_items [10];
		int          cap;
		logic [63:0] key;
		phase_limit = '{3, 1, 127, 20, 64, 0, -1, -1, -1, -1};
		phase_items = '{60, 50, 180, 80, 150, 40, 70, 70, 70, 70};

		// Limit zero behaves as one slot: fill, hit, then evict the single slot.
		probes.push_back(set_limit(32'd0));
		probes.push_back(ask(lpcd_pkg::CMD_WRITE, KEY_ONES, 0, 1'b1, '0));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_ZERO, 0, 1'b1,
			outcome(1'b0, 1'b1, 0, 0, 1'b1, 1'b0, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_ZERO, 4095, 1'b1,
			outcome(1'b1, 1'b1, 0, 4095, 1'b0, 1'b0, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_ONES, 4095, 1'b1,
			outcome(1'b0, 1'b1, 0, 4095, 1'b1, 1'b1, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_WRITE, KEY_ZERO, 0, 1'b1, '0));
		probes.push_back(ask(lpcd_pkg::CMD_WRITE, KEY_ONES, 0, 1'b1,
			outcome(1'b1, 1'b1, 0, 0, 1'b0, 1'b0, KEY_ZERO)));
		// A limit above the depth behaves as the full depth.
		probes.push_back(set_limit(32'd127));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_A, 'hAAA, 1'b1,
			outcome(1'b0, 1'b1, 1, 'h1AAA, 1'b1, 1'b0, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_B, 'h555, 1'b1,
			outcome(1'b0, 1'b1, 2, 'h2555, 1'b1, 1'b0, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_C, 1, 1'b1,
			outcome(1'b0, 1'b1, 3, 'h3001, 1'b1, 1'b0, KEY_ZERO)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_A, 0, 1'b1,
			outcome(1'b1, 1'b1, 1, 'h1000, 1'b0, 1'b0, KEY_ZERO)));
		// Limit lowered below the slots in use: misses evict among all used slots.
		probes.push_back(set_limit(32'd2));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_ZERO, 'h7FF, 1'b1,
			outcome(1'b0, 1'b1, 0, 'h7FF, 1'b1, 1'b1, KEY_ONES)));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_B, 0, 1'b0, '0));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_D, 'hFFF, 1'b0, '0));
		probes.push_back(ask(lpcd_pkg::CMD_WRITE, KEY_E, 'h123, 1'b1, '0));
		probes.push_back(ask(lpcd_pkg::CMD_WRITE, KEY_B, 'hFFF, 1'b0, '0));
		probes.push_back(set_limit(32'd64));
		probes.push_back(ask(lpcd_pkg::CMD_READ, 64'h1, 'h800, 1'b0, '0));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_ONES, 0, 1'b0, '0));
		probes.push_back(ask(lpcd_pkg::CMD_READ, KEY_D, 'h321, 1'b0, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The page limit comes out of reset at the full depth.
		read_page_limit(seen);
		check_field("page_limit", 64'(lpcd_pkg::LIMIT_RESET), 64'(seen));

		foreach (probes[i]) begin
			if (probes[i].is_cfg) begin
				settle();
				write_page_limit(probes[i].word);
			end else
				offer_request(probes[i].cmd, probes[i].key, probes[i].off,
					probes[i].typed, probes[i].want);
		end

		// Random phases: a pool of keys per phase, part of it already resident.
		for (int p = 0; p < 10; p++) begin
			word = (phase_limit[p] < 0) ? $urandom() : 32'(phase_limit[p]);
			settle();
			write_page_limit(word);
			cap = usable_slots();
			page_pool.delete();
			for (int i = 0; i < cap / 2 && i < dir_fill; i++)
				page_pool.push_back(dir_keys[$urandom_range(dir_fill - 1)]);
			while (page_pool.size() < cap + cap / 2 + 2)
				page_pool.push_back({$urandom(), $urandom()});
			no_idle = (p == 3);
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 4 && n == 10)
					hold_requests++;
				if ($urandom_range(9) == 0)
					key = {$urandom(), $urandom()};
				else
					key = page_pool[$urandom_range(page_pool.size() - 1)];
				offer_request(($urandom_range(3) == 0) ? lpcd_pkg::CMD_WRITE :
					lpcd_pkg::CMD_READ, key,
					lpcd_pkg::OFF_FIELD_W'($urandom_range(4095)), 1'b0, '0);
			end
		end
		no_idle = 1'b0;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("lru_page_cache_directory_tb: done, clean");
		else
			$display("lru_page_cache_directory_tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lpcd_pkg.sv
hw/rtl/lpcd_ram.sv
hw/rtl/lru_page_cache_directory.sv
dv/lru_page_cache_directory_tb.sv
